FILE: rtl/itlm_pkg.sv
// ----------------------------------------------------------------------------
// itlm_pkg: shared types and constants of the idle-time load monitor
// Sizes of the time base and the load ring, the command and result beat
// layouts, the operation and result codes, and the sequencer state types.
// ----------------------------------------------------------------------------
package itlm_pkg;

    // Storage and time base
    localparam int RING_DEPTH = 32;
    localparam int TIME_BITS  = 48;

    // Field widths of the beats and the register
    localparam int LOAD_W    = 15;
    localparam int WIN_W     = 6;
    localparam int ENTRIES_W = 6;

    // Derived widths
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int RING_CW    = $clog2(RING_DEPTH + 1);
    localparam int RING_XW    = RING_CW + 1;
    localparam int SUM_W      = LOAD_W + RING_CW;
    localparam int NUM_W      = TIME_BITS + LOAD_W;
    localparam int DIV_STEP_W = $clog2(LOAD_W + 1);

    // Load scale: 100 percent with 8 fraction bits
    localparam int FULL_SCALE = 25600;
    localparam int WIN_RESET  = 16;

    // Register port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_WINDOW_SIZE = '0;

    typedef enum logic [1:0] {
        OP_IDLE_ENTER   = 2'd0,
        OP_IDLE_EXIT    = 2'd1,
        OP_WINDOW_CLOSE = 2'd2,
        OP_AVG_QUERY    = 2'd3
    } itlm_op_t;

    typedef enum logic [1:0] {
        KIND_ACK   = 2'd0,
        KIND_LOAD  = 2'd1,
        KIND_AVG   = 2'd2,
        KIND_EMPTY = 2'd3
    } itlm_kind_t;

    typedef struct packed {
        itlm_op_t               operation;
        logic [TIME_BITS-1:0]   timestamp;
    } itlm_cmd_t;

    typedef struct packed {
        itlm_kind_t             result_kind;
        logic [LOAD_W-1:0]      load_value;
        logic                   zero_window;
        logic [ENTRIES_W-1:0]   entries_stored;
    } itlm_res_t;

    // Main sequencer
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCALE,
        S_DIV,
        S_PUSH,
        S_SUM,
        S_AVG,
        S_DONE
    } itlm_state_t;

    // Ring controller
    typedef enum logic [1:0] {
        RS_IDLE,
        RS_TRIM,
        RS_WRITE,
        RS_SUM
    } itlm_ring_state_t;

    typedef struct packed {
        logic                   start;
        logic [NUM_W-1:0]       num;
        logic [TIME_BITS-1:0]   den;
    } itlm_div_req_t;

    typedef struct packed {
        logic                   done;
        logic                   busy;
        logic [LOAD_W-1:0]      quot;
    } itlm_div_rsp_t;

    typedef struct packed {
        logic                   push;
        logic                   sum;
        logic [LOAD_W-1:0]      load;
    } itlm_ring_cmd_t;

    typedef struct packed {
        logic                   done;
        logic [SUM_W-1:0]       sum;
        logic [RING_CW-1:0]     count;
    } itlm_ring_rsp_t;

endpackage

FILE: rtl/idle_time_load_monitor.sv
// ----------------------------------------------------------------------------
// idle_time_load_monitor: processor load monitor from idle-time events
// Command beats (idle enter, idle exit, window close, average query) with a
// 48-bit timestamp go in; one result beat per command comes out. The window
// size register sits on an APB-style port at byte address 0.
//
// Usage:
//   cmd_valid/cmd_ready take one command beat; res_valid/res_ready return
//   its result. A command is taken only while the sequencer is idle.
//   Idle enter and idle exit go from the execute state straight to the result,
//   as does a query on an empty ring. A window close with zero length or full
//   idle skips the divider but still goes through the ring trim and write.
//   A window close that divides runs the shared one-bit-per-cycle divider,
//   then the ring trim and write.
//   An average query walks the stored loads through the ring RAM read port,
//   one entry per cycle, then runs the same divider.
//   The result sits in an output register; the next command is taken while
//   it waits, and a stalled receiver holds the sequencer only at its end.
//   Reset clears idle start, idle sum, window start, ring pointers and count, and
//   sets the window size to 16. The ring RAM is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
module idle_time_load_monitor (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [itlm_pkg::PADDR_W-1:0]    paddr,
    input  logic [itlm_pkg::PDATA_W-1:0]    pwdata,
    output logic [itlm_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready,
    input  logic                            cmd_valid,
    output logic                            cmd_ready,
    input  itlm_pkg::itlm_cmd_t             cmd,
    output logic                            res_valid,
    input  logic                            res_ready,
    output itlm_pkg::itlm_res_t             res
);
    import itlm_pkg::*;

    itlm_state_t            state_reg, state_next;
    logic [WIN_W-1:0]       win_reg, win_next;
    logic [RING_CW-1:0]     win_eff;
    logic                   reg_hit;
    logic                   cfg_write;

    itlm_op_t               op_reg, op_next;
    logic [TIME_BITS-1:0]   ts_reg, ts_next;
    logic [TIME_BITS-1:0]   idle_start_reg, idle_start_next;
    logic [TIME_BITS-1:0]   idle_acc_reg, idle_acc_next;
    logic [TIME_BITS-1:0]   wstart_reg, wstart_next;
    logic [TIME_BITS-1:0]   busy_time_reg, busy_time_next;
    logic [TIME_BITS-1:0]   total_reg, total_next;
    itlm_kind_t             kind_reg, kind_next;
    logic [LOAD_W-1:0]      load_reg, load_next;
    logic                   zero_reg, zero_next;
    itlm_res_t              res_reg, res_next;
    logic                   res_valid_reg, res_valid_next;
    logic                   res_load;

    logic [TIME_BITS-1:0]   total;
    logic [TIME_BITS-1:0]   idle_span;
    logic [NUM_W-1:0]       busy_ext;
    logic [NUM_W-1:0]       scaled;

    itlm_div_req_t          div_req;
    itlm_div_rsp_t          div_rsp;
    itlm_ring_cmd_t         ring_cmd;
    itlm_ring_rsp_t         ring_rsp;

    // Register port
    assign reg_hit   = (paddr[PADDR_W-1:2] == REG_WINDOW_SIZE);
    assign cfg_write = psel & penable & pwrite & reg_hit;
    assign win_next  = cfg_write ? pwdata[WIN_W-1:0] : win_reg;
    assign prdata    = reg_hit ? PDATA_W'(win_reg) : '0;
    assign pready    = 1'b1;

    // Clamp the window size into 1..RING_DEPTH
    always_comb
    begin
        if (win_reg == '0)
            win_eff = RING_CW'(1);
        else if (int'(win_reg) > RING_DEPTH)
            win_eff = RING_CW'(RING_DEPTH);
        else
            win_eff = RING_CW'(win_reg);
    end

    // Time differences wrap with the time base
    assign total     = ts_reg - wstart_reg;
    assign idle_span = ts_reg - idle_start_reg;

    // busy * 25600, with 25600 = 1024 * (16 + 8 + 1)
    assign busy_ext = NUM_W'(busy_time_reg);
    assign scaled   = (busy_ext << 14) + (busy_ext << 13) + (busy_ext << 10);

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        ts_next         = ts_reg;
        idle_start_next = idle_start_reg;
        idle_acc_next   = idle_acc_reg;
        wstart_next     = wstart_reg;
        busy_time_next  = busy_time_reg;
        total_next      = total_reg;
        kind_next       = kind_reg;
        load_next       = load_reg;
        zero_next       = zero_reg;
        cmd_ready       = 1'b0;
        res_load        = 1'b0;
        div_req.start   = 1'b0;
        div_req.num     = scaled;
        div_req.den     = total_reg;
        ring_cmd.push   = 1'b0;
        ring_cmd.sum    = 1'b0;
        ring_cmd.load   = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    op_next    = cmd.operation;
                    ts_next    = cmd.timestamp;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                kind_next = KIND_ACK;
                load_next = '0;
                zero_next = 1'b0;
                unique case (op_reg)
                    OP_IDLE_ENTER:
                    begin
                        idle_start_next = ts_reg;
                        state_next      = S_DONE;
                    end
                    OP_IDLE_EXIT:
                    begin
                        idle_acc_next = idle_acc_reg + idle_span;
                        state_next    = S_DONE;
                    end
                    OP_WINDOW_CLOSE:
                    begin
                        kind_next      = KIND_LOAD;
                        total_next     = total;
                        busy_time_next = total - idle_acc_reg;
                        idle_acc_next  = '0;
                        wstart_next    = ts_reg;
                        // zero-length window or idle covering it: store load 0
                        if (total == '0 || idle_acc_reg >= total)
                        begin
                            zero_next     = (total == '0);
                            ring_cmd.push = 1'b1;
                            state_next    = S_PUSH;
                        end
                        else
                            state_next = S_SCALE;
                    end
                    OP_AVG_QUERY:
                    begin
                        if (ring_rsp.count == '0)
                        begin
                            kind_next  = KIND_EMPTY;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            kind_next    = KIND_AVG;
                            ring_cmd.sum = 1'b1;
                            state_next   = S_SUM;
                        end
                    end
                endcase
            end
            S_SCALE:
            begin
                div_req.start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    load_next     = div_rsp.quot;
                    ring_cmd.push = 1'b1;
                    ring_cmd.load = div_rsp.quot;
                    state_next    = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (ring_rsp.done)
                    state_next = S_DONE;
            end
            S_SUM:
            begin
                if (ring_rsp.done)
                begin
                    div_req.start = 1'b1;
                    div_req.num   = NUM_W'(ring_rsp.sum);
                    div_req.den   = TIME_BITS'(ring_rsp.count);
                    state_next    = S_AVG;
                end
            end
            S_AVG:
            begin
                if (div_rsp.done)
                begin
                    load_next  = div_rsp.quot;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // hand the result to the output register once it is free
                if (!res_valid_reg || res_ready)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    // Output register
    always_comb
    begin
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        if (res_load)
        begin
            res_next.result_kind    = kind_reg;
            res_next.load_value     = load_reg;
            res_next.zero_window    = zero_reg;
            res_next.entries_stored = ENTRIES_W'(ring_rsp.count);
            res_valid_next          = 1'b1;
        end
        else if (res_ready)
            res_valid_next = 1'b0;
    end

    // Control and monitor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            win_reg        <= WIN_W'(WIN_RESET);
            idle_start_reg <= '0;
            idle_acc_reg   <= '0;
            wstart_reg     <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            win_reg        <= win_next;
            idle_start_reg <= idle_start_next;
            idle_acc_reg   <= idle_acc_next;
            wstart_reg     <= wstart_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        ts_reg        <= ts_next;
        busy_time_reg <= busy_time_next;
        total_reg     <= total_next;
        kind_reg      <= kind_next;
        load_reg      <= load_next;
        zero_reg      <= zero_next;
        res_reg       <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    itlm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    itlm_ring u_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (ring_cmd),
        .win   (win_eff),
        .rsp   (ring_rsp)
    );

    // A result beat never reports more than full load
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.load_value <= LOAD_W'(FULL_SCALE)))
        else $error("load above full scale");

    // The ring never reports more loads than it holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (int'(res.entries_stored) <= RING_DEPTH))
        else $error("ring count above depth");

    // Only a window load carries the zero-window flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.zero_window) |-> (res.result_kind == KIND_LOAD))
        else $error("zero-window flag on a non-load result");

    // The ring finishes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        ring_rsp.done |-> (state_reg == S_PUSH || state_reg == S_SUM))
        else $error("unexpected ring completion");

    // The divider is never restarted while it is busy
    assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

endmodule

FILE: rtl/itlm_div.sv
// ----------------------------------------------------------------------------
// itlm_div: shared restoring divider
// Produces a LOAD_W-bit quotient, one bit per cycle, from a numerator whose
// quotient by the divisor is known to fit in LOAD_W bits.
// ----------------------------------------------------------------------------
module itlm_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  itlm_pkg::itlm_div_req_t req,
    output itlm_pkg::itlm_div_rsp_t rsp
);
    import itlm_pkg::*;

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [DIV_STEP_W-1:0]  step_reg, step_next;
    logic [TIME_BITS-1:0]   rem_reg, rem_next;
    logic [LOAD_W-1:0]      quo_reg, quo_next;
    logic [TIME_BITS-1:0]   den_reg, den_next;
    logic [TIME_BITS:0]     trial;
    logic [TIME_BITS:0]     diff;
    logic                   fits;

    // Shift in the next numerator bit and try the subtraction
    always_comb
    begin
        trial = {rem_reg, quo_reg[LOAD_W-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = (trial >= {1'b0, den_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;

        if (req.start)
        begin
            rem_next  = req.num[NUM_W-1:LOAD_W];
            quo_next  = req.num[LOAD_W-1:0];
            den_next  = req.den;
            step_next = DIV_STEP_W'(LOAD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
            quo_next  = {quo_reg[LOAD_W-2:0], fits};
            step_next = step_reg - DIV_STEP_W'(1);
            if (step_reg == DIV_STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.busy = busy_reg;
    assign rsp.quot = quo_reg;

endmodule

FILE: rtl/itlm_ring.sv
// ----------------------------------------------------------------------------
// itlm_ring: ring of recent window loads
// Holds the loads in a RAM with one write and one read port, with oldest pointer and fill count,
// trims the ring to the window on a push, and sums the stored loads by a
// walk over the RAM, one entry per cycle.
// ----------------------------------------------------------------------------
module itlm_ring (
    input  logic                        clk,
    input  logic                        rst_n,
    input  itlm_pkg::itlm_ring_cmd_t    cmd,
    input  logic [itlm_pkg::RING_CW-1:0] win,
    output itlm_pkg::itlm_ring_rsp_t    rsp
);
    import itlm_pkg::*;

    logic [LOAD_W-1:0]  mem [RING_DEPTH];

    itlm_ring_state_t   state_reg, state_next;
    logic [RING_AW-1:0] oldest_reg, oldest_next;
    logic [RING_CW-1:0] count_reg, count_next;
    logic [RING_AW-1:0] ptr_reg, ptr_next;
    logic [RING_CW-1:0] issued_reg, issued_next;
    logic               pend_reg, pend_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [LOAD_W-1:0]  load_reg, load_next;
    logic [LOAD_W-1:0]  rd_data_reg;
    logic               we;
    logic [RING_AW-1:0] wr_addr;
    logic               done;

    // Add an offset to a ring index, wrapping at the depth
    function automatic logic [RING_AW-1:0] wrap_add(input logic [RING_AW-1:0] base,
                                                    input logic [RING_CW-1:0] offs);
        logic [RING_XW-1:0] s;
        s = RING_XW'(base) + RING_XW'(offs);
        if (s >= RING_XW'(RING_DEPTH))
            s = s - RING_XW'(RING_DEPTH);
        return s[RING_AW-1:0];
    endfunction

    // Next state and datapath control
    always_comb
    begin
        state_next  = state_reg;
        oldest_next = oldest_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        issued_next = issued_reg;
        pend_next   = pend_reg;
        sum_next    = sum_reg;
        load_next   = load_reg;
        we          = 1'b0;
        wr_addr     = wrap_add(oldest_reg, count_reg);
        done        = 1'b0;

        unique case (state_reg)
            RS_IDLE:
            begin
                if (cmd.push)
                begin
                    load_next  = cmd.load;
                    state_next = RS_TRIM;
                end
                else if (cmd.sum)
                begin
                    ptr_next    = oldest_reg;
                    issued_next = '0;
                    pend_next   = 1'b0;
                    sum_next    = '0;
                    state_next  = RS_SUM;
                end
            end
            RS_TRIM:
            begin
                // drop the oldest loads so the new one fits the window
                if (count_reg >= win)
                begin
                    oldest_next = wrap_add(oldest_reg, count_reg - win + RING_CW'(1));
                    count_next  = win - RING_CW'(1);
                end
                state_next = RS_WRITE;
            end
            RS_WRITE:
            begin
                we         = 1'b1;
                count_next = count_reg + RING_CW'(1);
                done       = 1'b1;
                state_next = RS_IDLE;
            end
            RS_SUM:
            begin
                // issue one read per cycle, accumulate the data in the following cycle
                pend_next = 1'b0;
                if (issued_reg != count_reg)
                begin
                    ptr_next    = wrap_add(ptr_reg, RING_CW'(1));
                    issued_next = issued_reg + RING_CW'(1);
                    pend_next   = 1'b1;
                end
                if (pend_reg)
                    sum_next = sum_reg + SUM_W'(rd_data_reg);
                if (issued_reg == count_reg && !pend_reg)
                begin
                    done       = 1'b1;
                    state_next = RS_IDLE;
                end
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= RS_IDLE;
            oldest_reg <= '0;
            count_reg  <= '0;
            ptr_reg    <= '0;
            issued_reg <= '0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            oldest_reg <= oldest_next;
            count_reg  <= count_next;
            ptr_reg    <= ptr_next;
            issued_reg <= issued_next;
            pend_reg   <= pend_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_next;
        load_reg <= load_next;
    end

    // Load RAM: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[wr_addr] <= load_reg;
        rd_data_reg <= mem[ptr_reg];
    end

    assign rsp.done  = done;
    assign rsp.sum   = sum_reg;
    assign rsp.count = count_reg;

endmodule
